>>> rtl/core/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg - bootloader block framer shared definitions
// Request codes, frame constants, the queued command type and the CRC step.
// ----------------------------------------------------------------------------
package bbf_pkg;

	typedef enum logic [1:0] {
		REQ_OPEN    = 2'd0,
		REQ_PAYLOAD = 2'd1,
		REQ_REPLY   = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	localparam logic [7:0]  MAX_BLOCK = 8'd255;
	localparam logic [7:0]  HDR_BYTE  = 8'h80;
	localparam logic [7:0]  CMD_BYTE  = 8'h10;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [8:0]  LEN_EXTRA = 9'd4;

	localparam logic [2:0]  REPLY_CHECKED = 3'd6;
	localparam logic [2:0]  REPLY_LAST    = 3'd7;

	// position within one frame
	localparam logic [3:0] STEP_SYNC   = 4'd0;
	localparam logic [3:0] STEP_LEN_LO = 4'd1;
	localparam logic [3:0] STEP_LEN_HI = 4'd2;
	localparam logic [3:0] STEP_CMD    = 4'd3;
	localparam logic [3:0] STEP_ADDR0  = 4'd4;
	localparam logic [3:0] STEP_ADDR1  = 4'd5;
	localparam logic [3:0] STEP_ADDR2  = 4'd6;
	localparam logic [3:0] STEP_DATA   = 4'd7;
	localparam logic [3:0] STEP_CRC_LO = 4'd8;
	localparam logic [3:0] STEP_CRC_HI = 4'd9;

	typedef struct packed {
		logic        has_hdr;
		logic        has_crc;
		logic        is_verdict;
		logic        ok;
		logic [7:0]  data;
		logic [23:0] addr;
		logic [8:0]  flen;
		logic [15:0] crc_val;
	} cmd_t;

	function automatic logic [7:0] ack_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd1: b = 8'h80;
			3'd2: b = 8'h02;
			3'd4: b = 8'h3B;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] x;
		x = crc[15:8] ^ b;
		x = x ^ (x >> 4);
		return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
	endfunction

endpackage

>>> rtl/core/bbf_front.sv
// ----------------------------------------------------------------------------
// bbf_front - request decoder
// Tracks section, block and reply state and turns each request into at most
// one command for the back end, with the frame CRC already worked out.
// ----------------------------------------------------------------------------
module bbf_front import bbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  req_t        req_type,
	input  logic [23:0] section_address,
	input  logic [23:0] section_length,
	input  logic [7:0]  data_byte,
	output logic        push,
	output cmd_t        cmd
);

	logic [23:0] section_left_q;
	logic [7:0]  block_left_q;
	logic [23:0] next_address_q;
	logic [15:0] running_crc_q;
	logic [2:0]  reply_count_q;
	logic        reply_match_q;

	logic        new_block;
	logic [7:0]  blen;
	logic [7:0]  bl_eff;
	logic [7:0]  bl_next;
	logic [15:0] crc_hdr;
	logic [15:0] crc_new;
	logic        byte_bad;

	always_comb begin
		new_block = (block_left_q == 8'd0);
		blen      = (section_left_q < {16'd0, MAX_BLOCK}) ? section_left_q[7:0] : MAX_BLOCK;
		bl_eff    = new_block ? blen : block_left_q;
		bl_next   = bl_eff - 8'd1;
		crc_hdr   = crc_step(CRC_INIT, CMD_BYTE);
		crc_hdr   = crc_step(crc_hdr, next_address_q[7:0]);
		crc_hdr   = crc_step(crc_hdr, next_address_q[15:8]);
		crc_hdr   = crc_step(crc_hdr, next_address_q[23:16]);
		crc_new   = crc_step(new_block ? crc_hdr : running_crc_q, data_byte);
		byte_bad  = (reply_count_q < REPLY_CHECKED) && (data_byte != ack_byte(reply_count_q));
	end

	always_comb begin
		push            = 1'b0;
		cmd.has_hdr     = new_block;
		cmd.has_crc     = (bl_next == 8'd0);
		cmd.is_verdict  = 1'b0;
		cmd.ok          = 1'b0;
		cmd.data        = data_byte;
		cmd.addr        = next_address_q;
		cmd.flen        = {1'b0, blen} + LEN_EXTRA;
		cmd.crc_val     = crc_new;
		if (accept) begin
			case (req_type)
				REQ_PAYLOAD: push = (section_left_q != 24'd0);
				REQ_REPLY: begin
					if (reply_count_q == REPLY_LAST) begin
						push           = 1'b1;
						cmd.is_verdict = 1'b1;
						cmd.has_hdr    = 1'b0;
						cmd.has_crc    = 1'b0;
						cmd.ok         = reply_match_q;
					end
				end
				default: push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_left_q <= 24'd0;
			block_left_q   <= 8'd0;
			next_address_q <= 24'd0;
			running_crc_q  <= CRC_INIT;
			reply_count_q  <= 3'd0;
			reply_match_q  <= 1'b1;
		end else if (accept) begin
			case (req_type)
				REQ_OPEN: begin
					section_left_q <= section_length;
					next_address_q <= section_address;
					block_left_q   <= 8'd0;
					running_crc_q  <= CRC_INIT;
				end
				REQ_PAYLOAD: begin
					if (section_left_q != 24'd0) begin
						if (new_block)
							next_address_q <= next_address_q + {16'd0, blen};
						running_crc_q  <= crc_new;
						block_left_q   <= bl_next;
						section_left_q <= section_left_q - 24'd1;
					end
				end
				REQ_REPLY: begin
					if (reply_count_q == REPLY_LAST) begin
						reply_count_q <= 3'd0;
						reply_match_q <= 1'b1;
					end else begin
						reply_count_q <= reply_count_q + 3'd1;
						reply_match_q <= reply_match_q & ~byte_bad;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/bbf_queue.sv
// ----------------------------------------------------------------------------
// bbf_queue - command queue
// Small register FIFO between the decoder and the frame sequencer.
// ----------------------------------------------------------------------------
module bbf_queue import bbf_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output logic full,
	output logic valid,
	output cmd_t data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign data    = mem_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

>>> rtl/core/bbf_back.sv
// ----------------------------------------------------------------------------
// bbf_back - frame sequencer
// Expands each queued command into its frame bytes or verdict, one result
// per cycle while m_tready is high, from a registered command and step counter.
// ----------------------------------------------------------------------------
module bbf_back import bbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_data,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_byte[7:0], reply_ok[8], zero fill
	output logic        m_tuser,   // out_kind
	output logic        m_tlast
);

	logic       cur_valid_q;
	cmd_t       cur_q;
	logic [3:0] idx_q;

	logic       last;
	logic       fire;
	logic       load;
	logic [7:0] out_byte;

	always_comb begin
		last = cur_q.is_verdict || (idx_q == STEP_CRC_HI)
			|| ((idx_q == STEP_DATA) && !cur_q.has_crc);
		fire = cur_valid_q & m_tready;
		load = ~cur_valid_q | (fire & last);
		pop  = load & q_valid;
	end

	always_comb begin
		case (idx_q)
			STEP_SYNC:   out_byte = HDR_BYTE;
			STEP_LEN_LO: out_byte = cur_q.flen[7:0];
			STEP_LEN_HI: out_byte = {7'd0, cur_q.flen[8]};
			STEP_CMD:    out_byte = CMD_BYTE;
			STEP_ADDR0:  out_byte = cur_q.addr[7:0];
			STEP_ADDR1:  out_byte = cur_q.addr[15:8];
			STEP_ADDR2:  out_byte = cur_q.addr[23:16];
			STEP_DATA:   out_byte = cur_q.data;
			STEP_CRC_LO: out_byte = cur_q.crc_val[7:0];
			STEP_CRC_HI: out_byte = cur_q.crc_val[15:8];
			default:     out_byte = 8'h00;
		endcase
		if (cur_q.is_verdict)
			out_byte = 8'h00;
	end

	assign m_tvalid = cur_valid_q;
	assign m_tdata  = {7'd0, cur_q.is_verdict & cur_q.ok, out_byte};
	assign m_tuser  = cur_q.is_verdict;
	assign m_tlast  = last;

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= STEP_SYNC;
		end else if (load) begin
			cur_valid_q <= q_valid;
			idx_q       <= q_data.has_hdr ? STEP_SYNC : STEP_DATA;
		end else if (fire) begin
			idx_q <= idx_q + 4'd1;
		end
	end

endmodule

>>> rtl/core/bootloader_block_framer_top.sv
// ----------------------------------------------------------------------------
// bootloader_block_framer_top - bootloader block framer
// Cuts section payload into frames with header and CRC-CCITT, and checks
// the target's reply bytes, giving one verdict per eight.
//
//  channel | dir | tdata                                    | tuser    | tlast
//  s_*     | in  | section_address, section_length, data_byte | req_type | -
//  m_*     | out | out_byte, reply_ok                       | out_kind | last_of_run
//
// A request is taken every cycle while the command queue has room.
// Payload bytes give one result each, plus seven header bytes at a block's
// start and two CRC bytes at its end; the sequencer sends one result per
// cycle while m_tready is high, so a block of n bytes gives n+9 results.
// m_tready low stalls the sequencer; s_tready drops once the queue fills.
// arst_n clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module bootloader_block_framer_top import bbf_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // section_address[23:0], section_length[47:24], data_byte[55:48]
	input  logic [1:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_byte[7:0], reply_ok[8], zero fill
	output logic        m_tuser,   // out_kind
	output logic        m_tlast    // last_of_run
);

	logic accept;
	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_valid;
	cmd_t q_data;
	logic pop;

	assign s_tready = ~q_full;
	assign accept   = s_tvalid & s_tready;

	bbf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.req_type        (req_t'(s_tuser)),
		.section_address (s_tdata[23:0]),
		.section_length  (s_tdata[47:24]),
		.data_byte       (s_tdata[55:48]),
		.push            (push),
		.cmd             (push_cmd)
	);

	bbf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.valid     (q_valid),
		.data      (q_data)
	);

	bbf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
